### rtl/core/zim_pkg.sv
// Shared types, constants and helpers of the zone interval merger.
`timescale 1ns / 1ps

package zim_pkg;

	// Field widths fixed by the sample and result formats.
	localparam int unsigned TIME_W = 32;
	localparam int unsigned DIST_W = 24;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 3;

	// All-ones distance stands for "no sample seen yet".
	localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};

	// Register indexes, taken from paddr[2].
	localparam logic REG_MIN_DURATION = 1'b0;
	localparam logic REG_MIN_GAP      = 1'b1;

	// One input word: a trajectory sample.
	typedef struct packed {
		logic              in_zone;
		logic [TIME_W-1:0] sample_time;
		logic [DIST_W-1:0] obstacle_distance;
		logic              last_sample;
	} sample_t;

	// One output word: a merged interval or an end marker.
	typedef struct packed {
		logic              present;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic [DIST_W-1:0] min_distance;
		logic              final_result;
	} result_t;

	// Configuration seen by the merge logic.
	typedef struct packed {
		logic [TIME_W-1:0] min_duration;
		logic [TIME_W-1:0] min_gap;
	} cfg_t;

	// Up to two results produced by one sample, first result first.
	typedef struct packed {
		logic    r0_valid;
		result_t r0;
		logic    r1_valid;
		result_t r1;
	} res_pair_t;

	// Smaller of two distances.
	function automatic logic [DIST_W-1:0] dist_min(input logic [DIST_W-1:0] a,
		input logic [DIST_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

### rtl/core/zim_regs.sv
// APB configuration registers of the zone interval merger.
`timescale 1ns / 1ps

module zim_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [zim_pkg::ADDR_W-1:0]   paddr,
	input  logic [zim_pkg::DATA_W-1:0]   pwdata,
	output logic [zim_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output zim_pkg::cfg_t                cfg
);

	logic [zim_pkg::TIME_W-1:0] min_duration_q;
	logic [zim_pkg::TIME_W-1:0] min_gap_q;
	logic                       wr_en;

	// The port never inserts wait states.
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duration_q <= '0;
			min_gap_q      <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				zim_pkg::REG_MIN_DURATION: min_duration_q <= pwdata;
				zim_pkg::REG_MIN_GAP:      min_gap_q      <= pwdata;
				default:                   min_duration_q <= min_duration_q;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		unique case (paddr[2])
			zim_pkg::REG_MIN_DURATION: prdata = min_duration_q;
			zim_pkg::REG_MIN_GAP:      prdata = min_gap_q;
			default:                   prdata = '0;
		endcase
	end

	assign cfg.min_duration = min_duration_q;
	assign cfg.min_gap      = min_gap_q;

endmodule

### rtl/core/zim_core.sv
// Interval tracking and merge state, updated once per sample.
`timescale 1ns / 1ps

module zim_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  zim_pkg::sample_t    word,
	input  zim_pkg::cfg_t       cfg,
	output zim_pkg::res_pair_t  pair
);

	logic                       prev_flag_q;
	logic [zim_pkg::TIME_W-1:0] prev_time_q;
	logic [zim_pkg::TIME_W-1:0] raw_start_q;
	logic [zim_pkg::DIST_W-1:0] raw_min_q;
	logic [zim_pkg::DIST_W-1:0] after_min_q;
	logic                       pend_valid_q;
	logic [zim_pkg::TIME_W-1:0] pend_start_q;
	logic [zim_pkg::TIME_W-1:0] pend_end_q;
	logic [zim_pkg::DIST_W-1:0] pend_min_q;

	logic                       f;
	logic                       last;
	logic [zim_pkg::TIME_W-1:0] t;
	logic [zim_pkg::DIST_W-1:0] d;
	logic                       close_a;
	logic                       close_b;
	logic                       close_en;
	logic [zim_pkg::TIME_W-1:0] rs;
	logic [zim_pkg::TIME_W-1:0] re;
	logic [zim_pkg::DIST_W-1:0] d_min_raw;
	logic [zim_pkg::DIST_W-1:0] rmin;
	logic [zim_pkg::DIST_W-1:0] am_upd;
	logic [zim_pkg::DIST_W-1:0] am_in;
	logic [zim_pkg::DIST_W-1:0] am_mid;
	logic [zim_pkg::DIST_W-1:0] am_next;
	logic [zim_pkg::TIME_W:0]   dur_diff;
	logic [zim_pkg::TIME_W-1:0] prev_end;
	logic [zim_pkg::TIME_W:0]   gap_diff;
	logic                       keep;
	logic                       separate;
	logic                       sep_emit;
	logic                       pv_c;
	logic [zim_pkg::TIME_W-1:0] ps_c;
	logic [zim_pkg::TIME_W-1:0] pe_c;
	logic [zim_pkg::DIST_W-1:0] pm_c;
	logic [zim_pkg::TIME_W-1:0] raw_start_d;
	logic [zim_pkg::DIST_W-1:0] raw_min_d;
	zim_pkg::result_t           old_res;
	zim_pkg::result_t           fin_res;

	assign f    = word.in_zone;
	assign last = word.last_sample;
	assign t    = word.sample_time;
	assign d    = word.obstacle_distance;

	// A raw interval closes when a run ends, or when the trajectory ends inside a run.
	assign close_a  = prev_flag_q & ~f;
	assign close_b  = last & f;
	assign close_en = close_a | close_b;

	// Raw interval bounds and its least distance.
	assign d_min_raw = zim_pkg::dist_min(raw_min_q, d);
	assign rs        = prev_flag_q ? raw_start_q : t;
	assign re        = close_a ? prev_time_q : t;
	assign rmin      = close_a ? raw_min_q : (prev_flag_q ? d_min_raw : d);

	// Distance floor since the pending end; the closing sample of a run
	// that ended earlier is folded in only after the close.
	assign am_upd = zim_pkg::dist_min(after_min_q, d);
	assign am_in  = close_a ? after_min_q : am_upd;

	// Duration test with a borrow bit so that a reversed interval fails.
	assign dur_diff = {1'b0, re} - {1'b0, rs};
	assign keep     = close_en & ~dur_diff[zim_pkg::TIME_W]
		& (dur_diff[zim_pkg::TIME_W-1:0] > cfg.min_duration);

	// Gap test against the pending end, or time zero when nothing is pending.
	assign prev_end = pend_valid_q ? pend_end_q : '0;
	assign gap_diff = {1'b0, rs} - {1'b0, prev_end};
	assign separate = ~gap_diff[zim_pkg::TIME_W]
		& (gap_diff[zim_pkg::TIME_W-1:0] > cfg.min_gap);
	assign sep_emit = keep & separate & pend_valid_q;

	// Pending interval after the close.
	always_comb begin
		pv_c = pend_valid_q;
		ps_c = pend_start_q;
		pe_c = pend_end_q;
		pm_c = pend_min_q;
		if (keep) begin
			if (separate) begin
				pv_c = 1'b1;
				ps_c = rs;
				pe_c = re;
				pm_c = rmin;
			end else if (!pend_valid_q) begin
				pv_c = 1'b1;
				ps_c = '0;
				pe_c = re;
				pm_c = am_in;
			end else begin
				pe_c = re;
				pm_c = zim_pkg::dist_min(pend_min_q, am_in);
			end
		end
	end

	assign am_mid  = keep ? zim_pkg::DIST_ONES : am_in;
	assign am_next = close_a ? zim_pkg::dist_min(am_mid, d) : am_mid;

	// Raw run tracking.
	always_comb begin
		raw_start_d = raw_start_q;
		raw_min_d   = raw_min_q;
		if (!prev_flag_q && f) begin
			raw_start_d = t;
			raw_min_d   = d;
		end else if (prev_flag_q && f) begin
			raw_min_d = d_min_raw;
		end
	end

	// Results: a displaced pending interval, then the end-of-trajectory word.
	always_comb begin
		old_res.present      = 1'b1;
		old_res.start_time   = pend_start_q;
		old_res.end_time     = pend_end_q;
		old_res.min_distance = pend_min_q;
		old_res.final_result = 1'b0;
		fin_res.present      = pv_c;
		fin_res.start_time   = pv_c ? ps_c : '0;
		fin_res.end_time     = pv_c ? pe_c : '0;
		fin_res.min_distance = pv_c ? pm_c : '0;
		fin_res.final_result = 1'b1;
	end

	assign pair.r0_valid = sep_emit | last;
	assign pair.r0       = sep_emit ? old_res : fin_res;
	assign pair.r1_valid = sep_emit & last;
	assign pair.r1       = fin_res;

	// State update; the last sample returns everything to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_flag_q  <= 1'b0;
			prev_time_q  <= '0;
			raw_start_q  <= '0;
			raw_min_q    <= zim_pkg::DIST_ONES;
			after_min_q  <= zim_pkg::DIST_ONES;
			pend_valid_q <= 1'b0;
			pend_start_q <= '0;
			pend_end_q   <= '0;
			pend_min_q   <= zim_pkg::DIST_ONES;
		end else if (fire) begin
			if (last) begin
				prev_flag_q  <= 1'b0;
				prev_time_q  <= '0;
				raw_start_q  <= '0;
				raw_min_q    <= zim_pkg::DIST_ONES;
				after_min_q  <= zim_pkg::DIST_ONES;
				pend_valid_q <= 1'b0;
				pend_start_q <= '0;
				pend_end_q   <= '0;
				pend_min_q   <= zim_pkg::DIST_ONES;
			end else begin
				prev_flag_q  <= f;
				prev_time_q  <= t;
				raw_start_q  <= raw_start_d;
				raw_min_q    <= raw_min_d;
				after_min_q  <= am_next;
				pend_valid_q <= pv_c;
				pend_start_q <= ps_c;
				pend_end_q   <= pe_c;
				pend_min_q   <= pm_c;
			end
		end
	end

endmodule

### rtl/core/zim_out_buf.sv
// Result register with one spare slot for a sample that yields two words.
`timescale 1ns / 1ps

module zim_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  zim_pkg::res_pair_t pair,
	input  logic               result_ready,
	output logic               result_valid,
	output zim_pkg::result_t   result,
	output logic               room
);

	logic             out_valid_q;
	zim_pkg::result_t out_q;
	logic             spare_valid_q;
	zim_pkg::result_t spare_q;
	logic             pop;

	assign pop          = out_valid_q & result_ready;
	assign room         = ~spare_valid_q & (~out_valid_q | result_ready);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q   <= pair.r0_valid;
			spare_valid_q <= pair.r1_valid;
		end else if (pop) begin
			out_valid_q   <= spare_valid_q;
			spare_valid_q <= 1'b0;
		end
	end

	// Payload slots.
	always_ff @(posedge clk) begin
		if (push) begin
			out_q   <= pair.r0;
			spare_q <= pair.r1;
		end else if (pop) begin
			out_q <= spare_q;
		end
	end

endmodule

### rtl/core/zone_interval_merger_top.sv
// Top level of the zone interval merger: input register, merge core, result buffer.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                      word
//  sample    in         sample_valid / sample_ready    zim_pkg::sample_t
//  result    out        result_valid / result_ready    zim_pkg::result_t
//  config    in         APB psel/penable/pwrite/pready min_duration @0x0, min_gap @0x4
//
//  A sample is registered on acceptance and merged once the result buffer has
//  room; its result words go into the result register. While the result side is
//  ready and no sample yields two words, one sample per cycle is sustained.
//  A sample that closes one interval and ends the trajectory yields two words;
//  the second waits in the spare slot and holds the merge stage until the first word is taken.
//  Reset clears all tracking state; no clearing pass is needed.
//  A stalled result side backs up through the input register to sample_ready.

module zone_interval_merger_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  zim_pkg::sample_t           sample,
	output logic                       result_valid,
	input  logic                       result_ready,
	output zim_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [zim_pkg::ADDR_W-1:0] paddr,
	input  logic [zim_pkg::DATA_W-1:0] pwdata,
	output logic [zim_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	logic               valid_s1;
	zim_pkg::sample_t   word_s1;
	logic               room;
	logic               fire;
	zim_pkg::cfg_t      cfg;
	zim_pkg::res_pair_t pair;

	// Merge when a sample is held and the buffer can take both possible words.
	assign fire         = valid_s1 & room;
	assign sample_ready = ~valid_s1 | fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_valid && sample_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			word_s1 <= sample;
		end
	end

	zim_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	zim_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.word   (word_s1),
		.cfg    (cfg),
		.pair   (pair)
	);

	zim_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (fire),
		.pair         (pair),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result),
		.room         (room)
	);

	// A second word is only ever produced behind a first one.
	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pair.r1_valid |-> pair.r0_valid)
		else $error("second result without a first");

	// With two words, only the second closes the trajectory.
	a_final_order: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pair.r1_valid |-> pair.r1.final_result && !pair.r0.final_result)
		else $error("final flag on the wrong word");

	// The last sample always yields at least one word.
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && word_s1.last_sample |-> pair.r0_valid && pair.r0.final_result
			|| fire && word_s1.last_sample && pair.r1_valid)
		else $error("last sample without a final word");

	// The buffer refuses work only while it shows a word.
	a_room_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!room |-> result_valid)
		else $error("buffer blocked while empty");

endmodule
